// ===== rtl/bpas_pkg.sv =====
// Shared types and constants for the Bezier point splat block.
// Used by every module under rtl/ and by the channel interfaces.
package bpas_pkg;

  localparam int MAX_POINTS_DEF  = 6;
  localparam int COORD_BITS_DEF  = 10;

  localparam int T_W        = 17;
  localparam int T_FRAC     = 16;
  localparam logic [T_W-1:0] T_ONE = 17'd65536;
  localparam int FRAC_BITS  = 6;
  localparam int NUM_PT_REGS = 6;
  localparam int IDX_W      = 3;
  localparam int NEFF_W     = 4;
  localparam int OUT_W      = 12;
  localparam int INTEN_W    = 8;
  localparam int A_W        = 12;
  localparam int B_W        = 15;
  localparam int C_W        = 30;
  localparam int U2_W       = 18;
  localparam int SHADE_STEPS = 8;

  localparam logic [IDX_W-1:0] REG_POINT_COUNT = 3'd6;
  localparam logic [2:0]       POINT_COUNT_RST = 3'd6;
  localparam logic [C_W-1:0]   SHADE_SCALE     = 30'd260100;
  localparam logic [INTEN_W-1:0] FULL_INTEN    = 8'd255;

  typedef enum logic [3:0] {
    SLOT_CENTRE = 4'b0001,
    SLOT_HORIZ  = 4'b0010,
    SLOT_VERT   = 4'b0100,
    SLOT_DIAG   = 4'b1000
  } slot_e;

  typedef struct packed {
    logic [OUT_W-1:0] fx;
    logic [OUT_W-1:0] fy;
    logic [OUT_W-1:0] nx;
    logic [OUT_W-1:0] ny;
  } geom_t;

  typedef struct packed {
    geom_t                      g;
    logic [C_W-1:0]             c;
    logic [2:0][B_W-1:0]        b;
    logic [2:0][U2_W-1:0]       u2;
    logic [2:0][INTEN_W-1:0]    k;
  } shade_t;

endpackage

// ===== rtl/bpas_if.sv =====
// Request channels of the splat block: curve parameter in, pixel writes out.
// Depends on bpas_pkg for field widths.
interface bpas_t_if;
  logic                        valid;
  logic                        ready;
  logic [bpas_pkg::T_W-1:0]    t_value;
  modport source (output valid, output t_value, input ready);
  modport sink   (input valid, input t_value, output ready);
endinterface

interface bpas_pix_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bpas_pkg::OUT_W-1:0]    pixel_x;
  logic signed [bpas_pkg::OUT_W-1:0]    pixel_y;
  logic [bpas_pkg::INTEN_W-1:0]         intensity;
  logic                                 last_write;
  modport source (output valid, output pixel_x, output pixel_y, output intensity,
                  output last_write, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input intensity,
                  input last_write, output ready);
endinterface

// ===== rtl/bezier_point_antialias_splat.sv =====
// Bezier point evaluator with a four-pixel anti-aliasing splat.
//
// Control points and the point count are to be written through the cfg_* port
// only while the block is idle, which the block itself does not enforce. Each
// request on in_i carries a curve parameter t in Q1.16; values above 1.0 are
// clamped. The block evaluates the curve with a chain of MAX_POINTS-1
// interpolation cells, one de Casteljau level each, then two geometry stages
// and eight search cells that find the neighbour intensities one bit per cell.
// The output register emits four write requests on pix_o: the centre pixel at
// full intensity, then the horizontal, vertical and diagonal neighbours; the
// last carries last_write. Each t makes four writes through the single pixel
// write port; the next point enters as the last write of the one before goes.
// A stalled receiver holds the current write; the chain keeps filling until
// every cell is occupied, then in_i.ready drops.
// Reset empties the chain, clears all control points to zero and sets the
// point count to six.
module bezier_point_antialias_splat #(
  parameter int MAX_POINTS = bpas_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = bpas_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpas_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [2*COORD_BITS-1:0]       cfg_data_i,
  bpas_t_if.sink                        in_i,
  bpas_pix_if.source                    pix_o
);
  import bpas_pkg::*;

  localparam int W  = COORD_BITS + FRAC_BITS;
  localparam int NP = MAX_POINTS;
  localparam int L  = MAX_POINTS - 1;

  logic [COORD_BITS-1:0] px_q [NUM_PT_REGS];
  logic [COORD_BITS-1:0] py_q [NUM_PT_REGS];
  logic [2:0]            cnt_q;
  logic [NEFF_W-1:0]     neff;
  logic [T_W-1:0]        t_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PT_REGS; i++) begin
        px_q[i] <= '0;
        py_q[i] <= '0;
      end
      cnt_q <= POINT_COUNT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < IDX_W'(NUM_PT_REGS)) begin
        px_q[cfg_idx_i] <= cfg_data_i[COORD_BITS-1:0];
        py_q[cfg_idx_i] <= cfg_data_i[2*COORD_BITS-1:COORD_BITS];
      end else if (cfg_idx_i == REG_POINT_COUNT) begin
        cnt_q <= cfg_data_i[2:0];
      end
    end
  end

  // A count of zero behaves as one point; larger counts stop at MAX_POINTS.
  always_comb begin
    if (cnt_q == 3'd0) begin
      neff = NEFF_W'(1);
    end else if (NEFF_W'(cnt_q) > NEFF_W'(MAX_POINTS)) begin
      neff = NEFF_W'(MAX_POINTS);
    end else begin
      neff = NEFF_W'(cnt_q);
    end
  end

  assign t_sat = (in_i.t_value > T_ONE) ? T_ONE : in_i.t_value;

  logic              lv [L+1];
  logic              lr [L+1];
  logic [T_W-1:0]    lt [L+1];
  logic [NEFF_W-1:0] lc [L+1];
  logic [W-1:0]      lx [L+1][NP];
  logic [W-1:0]      ly [L+1][NP];

  assign lv[0]    = in_i.valid;
  assign in_i.ready = lr[0];
  assign lt[0]    = t_sat;
  assign lc[0]    = neff;

  for (genvar i = 0; i < NP; i++) begin : g_entry
    if (i < NUM_PT_REGS) begin : g_reg
      assign lx[0][i] = {px_q[i], {FRAC_BITS{1'b0}}};
      assign ly[0][i] = {py_q[i], {FRAC_BITS{1'b0}}};
    end else begin : g_zero
      assign lx[0][i] = '0;
      assign ly[0][i] = '0;
    end
  end

  for (genvar k = 0; k < L; k++) begin : g_lerp
    bpas_lerp_cell #(
      .LEVEL (k),
      .NP    (NP),
      .W     (W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (lv[k]),
      .in_ready_o  (lr[k]),
      .in_t_i      (lt[k]),
      .in_cnt_i    (lc[k]),
      .in_x_i      (lx[k]),
      .in_y_i      (ly[k]),
      .out_valid_o (lv[k+1]),
      .out_ready_i (lr[k+1]),
      .out_t_o     (lt[k+1]),
      .out_cnt_o   (lc[k+1]),
      .out_x_o     (lx[k+1]),
      .out_y_o     (ly[k+1])
    );
  end

  logic   sv [SHADE_STEPS+1];
  logic   sr [SHADE_STEPS+1];
  shade_t sd [SHADE_STEPS+1];

  bpas_geom #(
    .W (W)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lv[L]),
    .in_ready_o  (lr[L]),
    .in_px_i     (lx[L][0]),
    .in_py_i     (ly[L][0]),
    .out_valid_o (sv[0]),
    .out_ready_i (sr[0]),
    .out_o       (sd[0])
  );

  for (genvar j = 0; j < SHADE_STEPS; j++) begin : g_shade
    bpas_shade_cell #(
      .BIT (SHADE_STEPS - 1 - j)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (sv[j]),
      .in_ready_o  (sr[j]),
      .in_i        (sd[j]),
      .out_valid_o (sv[j+1]),
      .out_ready_i (sr[j+1]),
      .out_o       (sd[j+1])
    );
  end

  bpas_splat_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sv[SHADE_STEPS]),
    .in_ready_o (sr[SHADE_STEPS]),
    .in_i       (sd[SHADE_STEPS]),
    .pix_o      (pix_o)
  );

endmodule

// ===== rtl/bpas_lerp_cell.sv =====
// One de Casteljau level: interpolates neighbouring points in every lane but the last.
// Depends on bpas_pkg.
module bpas_lerp_cell #(
  parameter int LEVEL = 0,
  parameter int NP    = 6,
  parameter int W     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bpas_pkg::T_W-1:0]      in_t_i,
  input  logic [bpas_pkg::NEFF_W-1:0]   in_cnt_i,
  input  logic [W-1:0]                  in_x_i [NP],
  input  logic [W-1:0]                  in_y_i [NP],
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bpas_pkg::T_W-1:0]      out_t_o,
  output logic [bpas_pkg::NEFF_W-1:0]   out_cnt_o,
  output logic [W-1:0]                  out_x_o [NP],
  output logic [W-1:0]                  out_y_o [NP]
);
  import bpas_pkg::*;

  localparam int S = W + T_W + 2;

  function automatic logic [W-1:0] lerp(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [T_W-1:0] t);
    logic signed [W:0]   diff;
    logic signed [S-1:0] prod;
    logic [S-1:0]        base;
    logic signed [S-1:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, t});
    base = S'({a, 16'h8000});
    sum  = prod + $signed(base);
    return sum[W+T_FRAC-1:T_FRAC];
  endfunction

  logic         valid_q;
  logic         active;
  logic [W-1:0] x_d [NP];
  logic [W-1:0] y_d [NP];

  // A level only takes part while it lies below the curve degree.
  assign active     = in_cnt_i > NEFF_W'(LEVEL + 1);
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      if (active && i < NP - 1) begin
        x_d[i] = lerp(in_x_i[i], in_x_i[(i+1) % NP], in_t_i);
        y_d[i] = lerp(in_y_i[i], in_y_i[(i+1) % NP], in_t_i);
      end else begin
        x_d[i] = in_x_i[i];
        y_d[i] = in_y_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      out_t_o   <= in_t_i;
      out_cnt_o <= in_cnt_i;
      out_x_o   <= x_d;
      out_y_o   <= y_d;
    end
  end

  assign out_valid_o = valid_q;

endmodule

// ===== rtl/bpas_geom.sv =====
// Pixel geometry of a curve point: pixel, neighbours and squared centre distances.
// Two register stages; depends on bpas_pkg.
module bpas_geom #(
  parameter int W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [W-1:0]         in_px_i,
  input  logic [W-1:0]         in_py_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bpas_pkg::shade_t     out_o
);
  import bpas_pkg::*;

  logic               v1_q, v2_q, s2_ready;
  geom_t              g_d, g_q;
  logic [A_W-1:0]     a_d, a_q;
  logic [2:0][B_W-1:0] b_d, b_q;
  logic [5:0]         rx, ry;
  logic signed [6:0]  dx0, dy0;
  logic signed [7:0]  dxn, dyn;
  logic signed [15:0] sx0, sy0, sxn, syn;

  assign rx  = in_px_i[FRAC_BITS-1:0];
  assign ry  = in_py_i[FRAC_BITS-1:0];
  assign dx0 = 7'sd32 - $signed({1'b0, rx});
  assign dy0 = 7'sd32 - $signed({1'b0, ry});
  // Half-way or beyond picks the neighbour on the plus side.
  assign dxn = {dx0[6], dx0} + (rx[5] ? 8'sd64 : -8'sd64);
  assign dyn = {dy0[6], dy0} + (ry[5] ? 8'sd64 : -8'sd64);
  assign sx0 = dx0 * dx0;
  assign sy0 = dy0 * dy0;
  assign sxn = dxn * dxn;
  assign syn = dyn * dyn;

  always_comb begin
    g_d.fx = OUT_W'(in_px_i[W-1:FRAC_BITS]);
    g_d.fy = OUT_W'(in_py_i[W-1:FRAC_BITS]);
    g_d.nx = rx[5] ? g_d.fx + OUT_W'(1) : g_d.fx - OUT_W'(1);
    g_d.ny = ry[5] ? g_d.fy + OUT_W'(1) : g_d.fy - OUT_W'(1);
    a_d    = A_W'(sx0) + A_W'(sy0);
    b_d[0] = B_W'(sxn) + B_W'(sy0);
    b_d[1] = B_W'(sx0) + B_W'(syn);
    b_d[2] = B_W'(sxn) + B_W'(syn);
  end

  assign s2_ready   = !v2_q || out_ready_i;
  assign in_ready_o = !v1_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (s2_ready) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      g_q <= g_d;
      a_q <= a_d;
      b_q <= b_d;
    end
    if (s2_ready && v1_q) begin
      out_o.g  <= g_q;
      out_o.c  <= C_W'(a_q) * SHADE_SCALE;
      out_o.b  <= b_q;
      out_o.u2 <= '0;
      out_o.k  <= '0;
    end
  end

  assign out_valid_o = v2_q;

endmodule

// ===== rtl/bpas_shade_cell.sv =====
// One bit of the intensity search for the three neighbour pixels.
// Keeps (2k)^2 alongside k so that no square is multiplied out; depends on bpas_pkg.
module bpas_shade_cell #(
  parameter int BIT = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bpas_pkg::shade_t     in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bpas_pkg::shade_t     out_o
);
  import bpas_pkg::*;

  localparam int DM1   = (2 ** (BIT + 1)) - 1;
  localparam int DM1SQ = DM1 * DM1;
  localparam int DSQ   = 4 ** (BIT + 1);

  logic   valid_q;
  shade_t d;

  assign in_ready_o = !valid_q || out_ready_i;

  // The trial value k+2^BIT stands if (2k'-1)^2 * B <= 4*65025*A.
  always_comb begin
    logic [19:0] m2;
    logic [32:0] prod;
    d = in_i;
    for (int l = 0; l < 3; l++) begin
      m2   = 20'(in_i.u2[l]) + (20'(in_i.k[l]) << (BIT + 3)) - (20'(in_i.k[l]) << 2)
             + 20'(DM1SQ);
      prod = 33'(m2[U2_W-1:0]) * 33'(in_i.b[l]);
      if (prod <= 33'(in_i.c)) begin
        d.k[l]  = in_i.k[l] | (INTEN_W'(1) << BIT);
        d.u2[l] = U2_W'(20'(in_i.u2[l]) + (20'(in_i.k[l]) << (BIT + 3)) + 20'(DSQ));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      out_o <= d;
    end
  end

  assign out_valid_o = valid_q;

endmodule

// ===== rtl/bpas_splat_out.sv =====
// Output register that turns one shaded point into four pixel write requests.
// Depends on bpas_pkg and bpas_pix_if.
module bpas_splat_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bpas_pkg::shade_t   in_i,
  bpas_pix_if.source         pix_o
);
  import bpas_pkg::*;

  logic   valid_q;
  slot_e  slot_q;
  shade_t item_q;

  assign in_ready_o = !valid_q || (pix_o.ready && slot_q == SLOT_DIAG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= SLOT_CENTRE;
    end else if (in_ready_o && in_valid_i) begin
      valid_q <= 1'b1;
      slot_q  <= SLOT_CENTRE;
    end else if (valid_q && pix_o.ready) begin
      unique case (slot_q)
        SLOT_CENTRE: slot_q <= SLOT_HORIZ;
        SLOT_HORIZ:  slot_q <= SLOT_VERT;
        SLOT_VERT:   slot_q <= SLOT_DIAG;
        SLOT_DIAG:   valid_q <= 1'b0;
        default:     slot_q <= SLOT_CENTRE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_i;
    end
  end

  always_comb begin
    pix_o.valid      = valid_q;
    pix_o.last_write = 1'b0;
    unique case (slot_q)
      SLOT_CENTRE: begin
        pix_o.pixel_x   = $signed(item_q.g.fx);
        pix_o.pixel_y   = $signed(item_q.g.fy);
        pix_o.intensity = FULL_INTEN;
      end
      SLOT_HORIZ: begin
        pix_o.pixel_x   = $signed(item_q.g.nx);
        pix_o.pixel_y   = $signed(item_q.g.fy);
        pix_o.intensity = item_q.k[0];
      end
      SLOT_VERT: begin
        pix_o.pixel_x   = $signed(item_q.g.fx);
        pix_o.pixel_y   = $signed(item_q.g.ny);
        pix_o.intensity = item_q.k[1];
      end
      SLOT_DIAG: begin
        pix_o.pixel_x    = $signed(item_q.g.nx);
        pix_o.pixel_y    = $signed(item_q.g.ny);
        pix_o.intensity  = item_q.k[2];
        pix_o.last_write = 1'b1;
      end
      default: begin
        pix_o.pixel_x   = '0;
        pix_o.pixel_y   = '0;
        pix_o.intensity = '0;
      end
    endcase
  end

endmodule

// ===== tb/bpas_test_if.sv =====
// Test-side register indexes of the splat block: no extra types are declared.
// The channel interfaces themselves come from rtl/bpas_if.sv and bpas_pkg.
package bpas_test_pkg;
  import bpas_pkg::*;
  localparam logic [IDX_W-1:0] REG_POINT_ZERO = 3'd0;
  localparam logic [IDX_W-1:0] REG_UNUSED     = 3'd7;
endpackage

// ===== tb/bpas_splat_checker.sv =====
// Watches the curve parameter and pixel write channels of the splat block,
// predicts the four writes per request and compares them. Depends on bpas_pkg.
module bpas_splat_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpas_pkg::IDX_W-1:0]       cfg_idx_i,
  input  logic [19:0]                      cfg_data_i,
  input  logic                             t_valid_i,
  input  logic                             t_ready_i,
  input  logic [bpas_pkg::T_W-1:0]         t_value_i,
  input  logic                             pix_valid_i,
  input  logic                             pix_ready_i,
  input  logic [bpas_pkg::OUT_W-1:0]       pixel_x_i,
  input  logic [bpas_pkg::OUT_W-1:0]       pixel_y_i,
  input  logic [bpas_pkg::INTEN_W-1:0]     intensity_i,
  input  logic                             last_write_i,
  output int                               mismatch_count_o,
  output int                               pending_writes_o
);
  import bpas_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0]   x;
    logic [OUT_W-1:0]   y;
    logic [INTEN_W-1:0] inten;
    logic               last;
  } pix_write_t;

  logic [9:0] ctrl_x [8];
  logic [9:0] ctrl_y [8];
  logic [2:0] count_q;
  pix_write_t expected_writes [$];

  function automatic logic [15:0] lerp_coord(logic [15:0] a, logic [15:0] b,
                                             logic [16:0] t);
    logic [63:0] s;
    s = 64'(a) * 64'(17'd65536 - t) + 64'(b) * 64'(t) + 64'd32768;
    return s[31:16];
  endfunction

  function automatic logic [15:0] curve_axis(logic [9:0] c [8], int n, logic [16:0] t);
    logic [15:0] w [8];
    for (int i = 0; i < 8; i++) w[i] = {c[i], 6'd0};
    for (int lvl = n; lvl > 1; lvl--)
      for (int i = 0; i + 1 < lvl; i++) w[i] = lerp_coord(w[i], w[i+1], t);
    return w[0];
  endfunction

  function automatic logic [7:0] neighbour_level(longint a, longint b);
    logic [7:0] best;
    longint m;
    best = 0;
    for (int k = 1; k <= 255; k++) begin
      m = 2 * k - 1;
      if (m * m * b <= 4 * 65025 * a) best = 8'(k);
    end
    return best;
  endfunction

  function automatic void add_write(logic [OUT_W-1:0] x, logic [OUT_W-1:0] y,
                                    logic [INTEN_W-1:0] inten, logic last);
    pix_write_t w;
    w = '{x, y, inten, last};
    expected_writes = {expected_writes, w};
  endfunction

  task automatic predict_splat(logic [T_W-1:0] tv);
    logic [16:0] t;
    int n, rx, ry, dx0, dy0, dxn, dyn;
    logic [15:0] px, py;
    logic [OUT_W-1:0] fx, fy, nx, ny;
    longint a;
    t = (tv > T_ONE) ? T_ONE : tv;
    n = count_q;
    if (n < 1) n = 1;
    if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
    px = curve_axis(ctrl_x, n, t);
    py = curve_axis(ctrl_y, n, t);
    fx = OUT_W'(px >> 6);
    fy = OUT_W'(py >> 6);
    rx = px[5:0];
    ry = py[5:0];
    nx = (rx >= 32) ? fx + OUT_W'(1) : fx - OUT_W'(1);
    ny = (ry >= 32) ? fy + OUT_W'(1) : fy - OUT_W'(1);
    dx0 = 32 - rx;
    dy0 = 32 - ry;
    dxn = dx0 + ((rx >= 32) ? 64 : -64);
    dyn = dy0 + ((ry >= 32) ? 64 : -64);
    a = dx0 * dx0 + dy0 * dy0;
    add_write(fx, fy, FULL_INTEN, 1'b0);
    add_write(nx, fy, neighbour_level(a, dxn*dxn + dy0*dy0), 1'b0);
    add_write(fx, ny, neighbour_level(a, dx0*dx0 + dyn*dyn), 1'b0);
    add_write(nx, ny, neighbour_level(a, dxn*dxn + dyn*dyn), 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_write_t want;
    pix_write_t got;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        ctrl_x[i] = '0;
        ctrl_y[i] = '0;
      end
      count_q = POINT_COUNT_RST;
      expected_writes.delete();
      mismatch_count_o = 0;
      pending_writes_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < NUM_PT_REGS) begin
          ctrl_x[cfg_idx_i] = cfg_data_i[9:0];
          ctrl_y[cfg_idx_i] = cfg_data_i[19:10];
        end else if (cfg_idx_i == REG_POINT_COUNT) begin
          count_q = cfg_data_i[2:0];
        end
      end
      if (pix_valid_i && pix_ready_i) begin
        got = '{pixel_x_i, pixel_y_i, intensity_i, last_write_i};
        if (expected_writes.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected write, expected none, actual %h", $time, got);
        end else begin
          want = expected_writes.pop_front();
          if (got !== want) begin
            mismatch_count_o++;
            $display("%0t: expected %0d,%0d,%0d,%0d actual %0d,%0d,%0d,%0d",
                     $time, $signed(want.x), $signed(want.y), want.inten, want.last,
                     $signed(got.x), $signed(got.y), got.inten, got.last);
          end
        end
      end
      if (t_valid_i && t_ready_i) predict_splat(t_value_i);
      pending_writes_o = expected_writes.size();
    end
  end

endmodule

// ===== tb/bezier_point_antialias_splat_test.sv =====
// Stimulus and verdict for the Bezier point splat block: writes control point
// settings between phases and sends curve parameters. Depends on the checker.
module bezier_point_antialias_splat_test;
  import bpas_pkg::*;
  import bpas_test_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [19:0]      cfg_data_i = '0;
  int               mismatch_count;
  int               pending_writes;
  int               send_idle_pct;
  int               take_idle_pct;

  bpas_t_if   t_ch ();
  bpas_pix_if pix_ch ();

  always #2 clk_i = ~clk_i;

  bezier_point_antialias_splat dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(t_ch.sink), .pix_o(pix_ch.source)
  );

  bpas_splat_checker checker_u (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .t_valid_i(t_ch.valid), .t_ready_i(t_ch.ready), .t_value_i(t_ch.t_value),
    .pix_valid_i(pix_ch.valid), .pix_ready_i(pix_ch.ready),
    .pixel_x_i(pix_ch.pixel_x), .pixel_y_i(pix_ch.pixel_y),
    .intensity_i(pix_ch.intensity), .last_write_i(pix_ch.last_write),
    .mismatch_count_o(mismatch_count), .pending_writes_o(pending_writes)
  );

  initial begin
    t_ch.valid = 1'b0;
    t_ch.t_value = '0;
    pix_ch.ready = 1'b0;
  end

  // The receiver stalls at random at the rate take_idle_pct sets; at zero it never stalls.
  always @(posedge clk_i) pix_ch.ready <= ($urandom_range(99) >= take_idle_pct);

  // The write enable stays high until the next request is sent.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [19:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic send_t(logic [T_W-1:0] tv);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      t_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    t_ch.valid   <= 1'b1;
    t_ch.t_value <= tv;
    do @(posedge clk_i); while (!t_ch.ready);
  endtask

  task automatic drain_writes();
    t_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_writes != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_points(int mode);
    for (int i = 0; i < NUM_PT_REGS; i++)
      case (mode)
        0: write_reg(REG_POINT_ZERO + IDX_W'(i), 20'h00000);
        1: write_reg(REG_POINT_ZERO + IDX_W'(i), 20'hFFFFF);
        default: write_reg(REG_POINT_ZERO + IDX_W'(i), 20'($urandom));
      endcase
  endtask

  function automatic logic [T_W-1:0] random_t();
    case ($urandom_range(9))
      0: return T_W'($urandom_range(65536, 131071));
      1: return T_W'($urandom_range(1) ? 65536 : 0);
      default: return T_W'($urandom_range(65536));
    endcase
  endfunction

  initial begin
    send_idle_pct = 33;
    take_idle_pct = 84;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: reset settings, then the extremes of points and counts.
    send_t(17'd0);
    send_t(T_ONE);
    drain_writes();
    random_points(1);
    write_reg(REG_POINT_COUNT, 20'd6);
    send_t(17'd0);
    send_t(17'd32768);
    send_t(17'h1FFFF);
    drain_writes();
    random_points(2);
    for (int c = 0; c < 8; c++) begin
      write_reg(REG_POINT_COUNT, 20'(c));
      write_reg(REG_UNUSED, 20'($urandom));
      send_t(17'd0);
      send_t(17'd21845);
      send_t(17'd65535);
      drain_writes();
    end
    // Random phases with the idling pattern rotated.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 84; take_idle_pct = 33; end
      if (ph == 8) begin send_idle_pct = 0;  take_idle_pct = 0;  end
      random_points(ph == 11 ? 0 : 2);
      write_reg(REG_POINT_COUNT, 20'($urandom_range(ph % 3 == 0 ? 7 : 6, 1)));
      for (int i = 0; i < 28; i++) send_t(random_t());
      drain_writes();
    end
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== bezier_point_antialias_splat.f =====
rtl/bpas_pkg.sv
rtl/bpas_if.sv
rtl/bpas_lerp_cell.sv
rtl/bpas_geom.sv
rtl/bpas_shade_cell.sv
rtl/bpas_splat_out.sv
rtl/bezier_point_antialias_splat.sv
tb/bpas_test_if.sv
tb/bpas_splat_checker.sv
tb/bezier_point_antialias_splat_test.sv
